@@ rtl/graph_edge_table_reachability_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the graph edge table
// Concurrent checks that disappear when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef GRAPH_EDGE_TABLE_REACHABILITY_ASSERT_SVH
`define GRAPH_EDGE_TABLE_REACHABILITY_ASSERT_SVH

`ifndef SYNTHESIS
`define GERT_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define GERT_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define GERT_ASSERT(lbl, clk, rst_n, prop, msg)
`define GERT_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

@@ rtl/gert_pkg.sv @@
// ----------------------------------------------------------------------------
// gert_pkg
// Widths, codes and shared types of the graph edge table.
// ----------------------------------------------------------------------------
package gert_pkg;

	localparam int NODES_DEF = 16;
	localparam int NODE_W    = 4;
	localparam int OP_W      = 2;
	localparam int ST_W      = 2;
	localparam int EDGE_W    = 9;
	localparam int CNT_W     = 5;
	localparam int CFG_AW    = 3;
	localparam int CFG_DW    = 32;

	localparam logic [CNT_W-1:0] NODE_COUNT_RST = 5'd16;

	// Register index of node_count (byte address bits above the word offset).
	localparam logic REG_NODE_COUNT = 1'b0;

	typedef enum logic [OP_W-1:0] {
		OP_ADD    = 2'd0,
		OP_REMOVE = 2'd1,
		OP_QUERY  = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK       = 2'd0,
		ST_NOCHANGE = 2'd1,
		ST_RANGE    = 2'd2
	} status_t;

	typedef struct packed {
		logic clear;
		logic push;
		logic pop;
	} stk_ctl_t;

endpackage

@@ rtl/gert_if.sv @@
// ----------------------------------------------------------------------------
// gert_cmd_if / gert_rsp_if
// Valid/ready channels for command words and result words.
// ----------------------------------------------------------------------------
interface gert_cmd_if;
	logic                        valid;
	logic                        ready;
	logic [gert_pkg::OP_W-1:0]   opcode;
	logic [gert_pkg::NODE_W-1:0] from_node;
	logic [gert_pkg::NODE_W-1:0] to_node;

	modport source (output valid, output opcode, output from_node, output to_node,
		input ready);
	modport sink (input valid, input opcode, input from_node, input to_node,
		output ready);
endinterface

interface gert_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [gert_pkg::ST_W-1:0]   status;
	logic                        path_found;
	logic [gert_pkg::EDGE_W-1:0] edge_total;

	modport source (output valid, output status, output path_found, output edge_total,
		input ready);
	modport sink (input valid, input status, input path_found, input edge_total,
		output ready);
endinterface

@@ rtl/graph_edge_table_reachability.sv @@
// ----------------------------------------------------------------------------
// graph_edge_table_reachability
// Steps: unused, out-of-range and self queries go from accept straight to the
// done step; add and remove read the row, then update it; a search repeats
// scan, pick, pop and pop-wait until the target is found or the stack is empty.
// One word at a time: a new command word is taken only in the idle state, and
// the done step waits until the result register is free.
// Reset clears the control state, the row valid bits, the edge count and sets
// node_count to 16; there is no clearing pass.
// ----------------------------------------------------------------------------
`include "graph_edge_table_reachability_assert.svh"

module graph_edge_table_reachability #(
	parameter int NODES = gert_pkg::NODES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [gert_pkg::CFG_AW-1:0] paddr,
	input  logic [gert_pkg::CFG_DW-1:0] pwdata,
	output logic [gert_pkg::CFG_DW-1:0] prdata,
	output logic                        pready,
	gert_cmd_if.sink                    cmd,
	gert_rsp_if.source                  rsp
);

	localparam int NW = (NODES > 1) ? $clog2(NODES) : 1;
	localparam int CW = ($clog2(NODES + 1) > gert_pkg::CNT_W) ?
		$clog2(NODES + 1) : gert_pkg::CNT_W;
	localparam logic [NODES-1:0] ONE = NODES'(1);

	typedef enum logic [6:0] {
		S_IDLE    = 7'b0000001,
		S_ROW     = 7'b0000010,
		S_SCAN    = 7'b0000100,
		S_PICK    = 7'b0001000,
		S_POP     = 7'b0010000,
		S_POPWAIT = 7'b0100000,
		S_DONE    = 7'b1000000
	} state_t;

	state_t                        state_q;
	gert_pkg::op_t                 op_q;
	gert_pkg::status_t             status_q;
	logic [NW-1:0]                 u_q;
	logic [NW-1:0]                 v_q;
	logic [NODES-1:0]              visited_q;
	logic [NODES-1:0]              fresh_q;
	logic                          path_q;
	logic [gert_pkg::EDGE_W-1:0]   edge_cnt_q;
	logic                          rsp_valid_q;
	logic [gert_pkg::ST_W-1:0]     rsp_status_q;
	logic                          rsp_path_q;
	logic [gert_pkg::EDGE_W-1:0]   rsp_edge_q;

	logic [gert_pkg::CNT_W-1:0]    node_count;
	logic [CW-1:0]                 cnt;
	logic [NODES-1:0]              range_mask;
	logic                          oor;
	logic                          accept;
	logic                          out_free;
	gert_pkg::op_t                 cmd_op;
	logic [NW-1:0]                 cmd_from;
	logic [NW-1:0]                 cmd_to;

	logic [NW-1:0]                 adj_rd_addr;
	logic [NODES-1:0]              adj_rd_data;
	logic                          adj_wr_en;
	logic [NODES-1:0]              adj_wr_data;
	logic                          row_bit;

	gert_pkg::stk_ctl_t            stk_ctl;
	logic [NW-1:0]                 stk_rdata;
	logic                          stk_empty;

	logic                          pick_any;
	logic [NW-1:0]                 pick_idx;
	logic [NODES-1:0]              pick_oh;

	gert_cfg u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.node_count (node_count)
	);

	gert_adj #(.NODES(NODES), .NW(NW)) u_adj (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (adj_rd_addr),
		.wr_en   (adj_wr_en),
		.wr_addr (u_q),
		.wr_data (adj_wr_data),
		.rd_data (adj_rd_data)
	);

	gert_stack #(.NODES(NODES), .NW(NW)) u_stack (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (stk_ctl),
		.wdata  (pick_idx),
		.rdata  (stk_rdata),
		.empty  (stk_empty)
	);

	gert_pick #(.NODES(NODES), .NW(NW)) u_pick (
		.vec (fresh_q),
		.any (pick_any),
		.idx (pick_idx)
	);

	// Effective node count is the register saturated to the table size.
	always_comb begin
		cnt = (CW'(node_count) > CW'(NODES)) ? CW'(NODES) : CW'(node_count);
		for (int i = 0; i < NODES; i++) begin
			range_mask[i] = (CW'(i) < cnt);
		end
	end

	assign cmd_op   = gert_pkg::op_t'(cmd.opcode);
	assign cmd_from = NW'(cmd.from_node);
	assign cmd_to   = NW'(cmd.to_node);
	assign oor      = (CW'(cmd.from_node) >= cnt) || (CW'(cmd.to_node) >= cnt);
	assign cmd.ready = (state_q == S_IDLE);
	assign accept   = cmd.valid && cmd.ready;
	assign out_free = !rsp_valid_q || rsp.ready;

	assign pick_oh  = ONE << pick_idx;
	assign row_bit  = adj_rd_data[v_q];

	always_comb begin
		unique case (state_q)
			S_IDLE:    adj_rd_addr = cmd_from;
			S_POPWAIT: adj_rd_addr = stk_rdata;
			default:   adj_rd_addr = u_q;
		endcase
	end

	assign adj_wr_en = (state_q == S_ROW) &&
		(((op_q == gert_pkg::OP_ADD) && !row_bit) ||
		 ((op_q == gert_pkg::OP_REMOVE) && row_bit));
	assign adj_wr_data = (op_q == gert_pkg::OP_ADD) ?
		(adj_rd_data | (ONE << v_q)) : (adj_rd_data & ~(ONE << v_q));

	always_comb begin
		stk_ctl.clear = accept && (cmd_op == gert_pkg::OP_QUERY);
		stk_ctl.push  = (state_q == S_PICK) && pick_any && (pick_idx != v_q);
		stk_ctl.pop   = (state_q == S_POP) && !stk_empty;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			edge_cnt_q  <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if ((state_q == S_DONE) && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if ((cmd_op == gert_pkg::OP_NONE) || oor ||
						    ((cmd_op == gert_pkg::OP_QUERY) && (cmd_from == cmd_to))) begin
							state_q <= S_DONE;
						end else if (cmd_op == gert_pkg::OP_QUERY) begin
							state_q <= S_SCAN;
						end else begin
							state_q <= S_ROW;
						end
					end
				end
				S_ROW: begin
					if (adj_wr_en) begin
						if (op_q == gert_pkg::OP_ADD) begin
							edge_cnt_q <= edge_cnt_q + gert_pkg::EDGE_W'(1);
						end else begin
							edge_cnt_q <= edge_cnt_q - gert_pkg::EDGE_W'(1);
						end
					end
					state_q <= S_DONE;
				end
				S_SCAN: begin
					state_q <= S_PICK;
				end
				S_PICK: begin
					if (pick_any) begin
						if (pick_idx == v_q) begin
							state_q <= S_DONE;
						end
					end else begin
						state_q <= S_POP;
					end
				end
				S_POP: begin
					state_q <= stk_empty ? S_DONE : S_POPWAIT;
				end
				S_POPWAIT: begin
					state_q <= S_SCAN;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_q      <= cmd_op;
					u_q       <= cmd_from;
					v_q       <= cmd_to;
					visited_q <= ONE << cmd_from;
					path_q    <= 1'b0;
					status_q  <= gert_pkg::ST_OK;
					if (cmd_op == gert_pkg::OP_NONE) begin
						status_q <= gert_pkg::ST_NOCHANGE;
					end else if (oor) begin
						status_q <= gert_pkg::ST_RANGE;
					end else if ((cmd_op == gert_pkg::OP_QUERY) && (cmd_from == cmd_to)) begin
						path_q <= 1'b1;
					end
				end
			end
			S_ROW: begin
				status_q <= adj_wr_en ? gert_pkg::ST_OK : gert_pkg::ST_NOCHANGE;
			end
			S_SCAN: begin
				fresh_q <= adj_rd_data & range_mask & ~visited_q;
			end
			S_PICK: begin
				if (pick_any) begin
					visited_q <= visited_q | pick_oh;
					fresh_q   <= fresh_q & ~pick_oh;
					if (pick_idx == v_q) begin
						path_q <= 1'b1;
					end
				end
			end
			S_DONE: begin
				if (out_free) begin
					rsp_status_q <= status_q;
					rsp_path_q   <= path_q;
					rsp_edge_q   <= edge_cnt_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.status     = rsp_status_q;
	assign rsp.path_found = rsp_path_q;
	assign rsp.edge_total = rsp_edge_q;

	// A new result word only appears after the sequencer has finished an item.
	`GERT_ASSERT(a_load_from_done, clk, arst_n,
		(state_q != S_DONE) && !rsp_valid_q |=> !rsp_valid_q,
		"result word appeared outside the done step")
	// The edge count moves only while an add or remove updates a row.
	`GERT_ASSERT(a_edge_only_in_row, clk, arst_n,
		(state_q != S_ROW) |=> $stable(edge_cnt_q),
		"edge count changed outside a row update")
	// Candidates for the pick are never nodes that the search already marked.
	`GERT_ASSERT_NEVER(a_fresh_unvisited, clk, arst_n,
		(state_q == S_PICK) && ((fresh_q & visited_q) != '0),
		"candidate node already visited")
	`GERT_ASSERT_NEVER(a_path_needs_ok, clk, arst_n,
		rsp.valid && rsp.path_found && (rsp.status != gert_pkg::ST_OK),
		"path reported with a failing status")

endmodule

@@ rtl/gert_cfg.sv @@
// ----------------------------------------------------------------------------
// gert_cfg
// APB register file holding the node count.
// ----------------------------------------------------------------------------
module gert_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [gert_pkg::CFG_AW-1:0] paddr,
	input  logic [gert_pkg::CFG_DW-1:0] pwdata,
	output logic [gert_pkg::CFG_DW-1:0] prdata,
	output logic                        pready,
	output logic [gert_pkg::CNT_W-1:0]  node_count
);

	logic [gert_pkg::CNT_W-1:0] node_count_q;
	logic                       hit;

	assign pready = 1'b1;
	assign hit    = (paddr[gert_pkg::CFG_AW-1:2] == gert_pkg::REG_NODE_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= gert_pkg::NODE_COUNT_RST;
		end else if (psel && penable && pwrite && pready && hit) begin
			node_count_q <= pwdata[gert_pkg::CNT_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (hit) begin
			prdata = {{(gert_pkg::CFG_DW-gert_pkg::CNT_W){1'b0}}, node_count_q};
		end
	end

	assign node_count = node_count_q;

endmodule

@@ rtl/gert_adj.sv @@
// ----------------------------------------------------------------------------
// gert_adj
// Adjacency row memory, one row per source node, registered read.
// ----------------------------------------------------------------------------
module gert_adj #(
	parameter int NODES = gert_pkg::NODES_DEF,
	parameter int NW    = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [NW-1:0]    rd_addr,
	input  logic             wr_en,
	input  logic [NW-1:0]    wr_addr,
	input  logic [NODES-1:0] wr_data,
	output logic [NODES-1:0] rd_data
);

	logic [NODES-1:0] mem [NODES];
	logic [NODES-1:0] row_valid_q;
	logic [NODES-1:0] rd_data_q;

	// A row that was never written since reset reads as empty.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
		end else if (wr_en) begin
			row_valid_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= row_valid_q[rd_addr] ? mem[rd_addr] : '0;
	end

	assign rd_data = rd_data_q;

endmodule

@@ rtl/gert_stack.sv @@
// ----------------------------------------------------------------------------
// gert_stack
// Search stack of node numbers with a registered pop read.
// ----------------------------------------------------------------------------
module gert_stack #(
	parameter int NODES = gert_pkg::NODES_DEF,
	parameter int NW    = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  gert_pkg::stk_ctl_t ctl,
	input  logic [NW-1:0]      wdata,
	output logic [NW-1:0]      rdata,
	output logic               empty
);

	localparam int SPW = $clog2(NODES + 1);

	logic [NW-1:0]  mem [NODES];
	logic [SPW-1:0] sp_q;
	logic [SPW-1:0] sp_m1;
	logic [NW-1:0]  rdata_q;

	assign sp_m1 = sp_q - SPW'(1);
	assign empty = (sp_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q <= '0;
		end else if (ctl.clear) begin
			sp_q <= '0;
		end else if (ctl.push) begin
			sp_q <= sp_q + SPW'(1);
		end else if (ctl.pop && !empty) begin
			sp_q <= sp_m1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			mem[sp_q[NW-1:0]] <= wdata;
		end
		if (ctl.pop) begin
			rdata_q <= mem[sp_m1[NW-1:0]];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/gert_pick.sv @@
// ----------------------------------------------------------------------------
// gert_pick
// Priority pick: lowest set bit of a row of candidate nodes.
// ----------------------------------------------------------------------------
module gert_pick #(
	parameter int NODES = gert_pkg::NODES_DEF,
	parameter int NW    = 4
) (
	input  logic [NODES-1:0] vec,
	output logic             any,
	output logic [NW-1:0]    idx
);

	always_comb begin
		any = 1'b0;
		idx = '0;
		for (int i = NODES - 1; i >= 0; i--) begin
			if (vec[i]) begin
				any = 1'b1;
				idx = NW'(i);
			end
		end
	end

endmodule

@@ tb/gert_result_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gert_result_checker
// Watches the command and result channels and the configuration port of the
// graph edge table, keeps its own copy of the adjacency matrix, edge count and
// node count, predicts one result word per accepted command word and compares
// every accepted result word field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module gert_result_checker
	import gert_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic              pready,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [CFG_DW-1:0] pwdata,
	gert_cmd_if               cmd,
	gert_rsp_if               rsp,
	output int                mismatches,
	output int                outstanding,
	output int                words_checked,
	output int                paths_found,
	output int                peak_edges
);

	typedef struct {
		status_t            status;
		logic               path;
		logic [EDGE_W-1:0]  edges;
	} outcome_t;

	logic [NODES_DEF-1:0] adj_rows [NODES_DEF];
	logic [EDGE_W-1:0]    edge_count;
	logic [CNT_W-1:0]     node_limit;
	outcome_t             pending_outcomes [$];
	int                   fail_n;
	int                   checked_n;
	int                   found_n;
	int                   peak_n;

	// Closure over the in-range part of the graph; a node reaches itself.
	function automatic logic reaches(input int src, input int dst,
			input logic [NODES_DEF-1:0] in_range);
		logic [NODES_DEF-1:0] seen;
		logic [NODES_DEF-1:0] grown;
		seen = '0;
		seen[src] = 1'b1;
		for (int pass = 0; pass < NODES_DEF; pass++) begin
			grown = seen;
			for (int n = 0; n < NODES_DEF; n++)
				if (seen[n])
					grown |= adj_rows[n] & in_range;
			seen = grown;
		end
		return seen[dst];
	endfunction

	function automatic outcome_t apply_command(input op_t op, input logic [NODE_W-1:0] u,
			input logic [NODE_W-1:0] v);
		outcome_t             res;
		int                   lim;
		logic [NODES_DEF-1:0] in_range;
		lim = (node_limit > NODES_DEF) ? NODES_DEF : int'(node_limit);
		in_range = NODES_DEF'((33'd1 << lim) - 33'd1);
		res.status = ST_OK;
		res.path = 1'b0;
		if (op == OP_NONE) begin
			res.status = ST_NOCHANGE;
		end else if (u >= lim || v >= lim) begin
			res.status = ST_RANGE;
		end else begin
			case (op)
				OP_ADD: begin
					if (adj_rows[u][v]) begin
						res.status = ST_NOCHANGE;
					end else begin
						adj_rows[u][v] = 1'b1;
						edge_count = edge_count + 1'b1;
					end
				end
				OP_REMOVE: begin
					if (adj_rows[u][v]) begin
						adj_rows[u][v] = 1'b0;
						edge_count = edge_count - 1'b1;
					end else begin
						res.status = ST_NOCHANGE;
					end
				end
				default: begin
					res.path = reaches(u, v, in_range);
				end
			endcase
		end
		res.edges = edge_count;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		outcome_t head;
		outcome_t predicted;
		if (!arst_n) begin
			for (int n = 0; n < NODES_DEF; n++)
				adj_rows[n] = '0;
			edge_count = '0;
			node_limit = NODE_COUNT_RST;
			pending_outcomes.delete();
			fail_n = 0;
			checked_n = 0;
			found_n = 0;
			peak_n = 0;
			mismatches <= 0;
			outstanding <= 0;
			words_checked <= 0;
			paths_found <= 0;
			peak_edges <= 0;
		end else begin
			if (cmd.valid && cmd.ready) begin
				predicted = apply_command(op_t'(cmd.opcode), cmd.from_node, cmd.to_node);
				pending_outcomes = {pending_outcomes, predicted};
				if (int'(edge_count) > peak_n)
					peak_n = int'(edge_count);
			end
			if (psel && penable && pwrite && pready &&
					paddr[CFG_AW-1:2] == REG_NODE_COUNT)
				node_limit = pwdata[CNT_W-1:0];
			if (rsp.valid && rsp.ready) begin
				if (pending_outcomes.size() == 0) begin
					$error("result word with no command word waiting: status %0d path %0d edges %0d",
						rsp.status, rsp.path_found, rsp.edge_total);
					fail_n++;
				end else begin
					head = pending_outcomes.pop_front();
					checked_n++;
					if (head.path)
						found_n++;
					if (rsp.status !== head.status) begin
						$error("status: expected %0d, got %0d", head.status, rsp.status);
						fail_n++;
					end
					if (rsp.path_found !== head.path) begin
						$error("path_found: expected %0d, got %0d", head.path, rsp.path_found);
						fail_n++;
					end
					if (rsp.edge_total !== head.edges) begin
						$error("edge_total: expected %0d, got %0d", head.edges, rsp.edge_total);
						fail_n++;
					end
				end
			end
			mismatches <= fail_n;
			outstanding <= pending_outcomes.size();
			words_checked <= checked_n;
			paths_found <= found_n;
			peak_edges <= peak_n;
		end
	end

endmodule

@@ tb/graph_edge_table_reachability_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// graph_edge_table_reachability_tb
// Drives the graph edge table with directed corner cases, a full fill and a
// thinning sweep of the matrix, and random add, remove and query traffic under
// several node counts, with random idling on both channels and one long
// result hold-off. A separate checker predicts and compares the result words.
// ----------------------------------------------------------------------------
module graph_edge_table_reachability_tb;
	import gert_pkg::*;

	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 5 * NODES_DEF + 20;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [CFG_AW-1:0] paddr;
	logic [CFG_DW-1:0] pwdata;
	logic [CFG_DW-1:0] prdata;
	logic              pready;

	int mismatches;
	int outstanding;
	int words_checked;
	int paths_found;
	int peak_edges;
	int cycle_count;
	int reg_writes;
	bit calm;
	bit hold_req;

	gert_cmd_if cmd_if();
	gert_rsp_if rsp_if();

	graph_edge_table_reachability dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cmd     (cmd_if),
		.rsp     (rsp_if)
	);

	gert_result_checker results (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.pready        (pready),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.cmd           (cmd_if),
		.rsp           (rsp_if),
		.mismatches    (mismatches),
		.outstanding   (outstanding),
		.words_checked (words_checked),
		.paths_found   (paths_found),
		.peak_edges    (peak_edges)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Mostly no gap, often a short one, now and then a long one.
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [NODE_W-1:0] pick_node(input int lim);
		if (lim > 0 && $urandom_range(0, 99) < 88)
			return NODE_W'($urandom_range(0, lim - 1));
		return NODE_W'($urandom_range(0, NODES_DEF - 1));
	endfunction

	task automatic send_word(input op_t op, input logic [NODE_W-1:0] u,
			input logic [NODE_W-1:0] v);
		int gap;
		gap = idle_len();
		if (gap > 0) begin
			cmd_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_if.valid <= 1'b1;
		cmd_if.opcode <= op;
		cmd_if.from_node <= u;
		cmd_if.to_node <= v;
		do @(posedge clk); while (!cmd_if.ready);
	endtask

	// Sender pauses until every predicted result word has come back.
	task automatic wait_idle();
		cmd_if.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic write_node_count(input logic [CNT_W-1:0] n);
		logic [CFG_DW-1:0] junk;
		junk = $urandom();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {REG_NODE_COUNT, 2'b00};
		pwdata <= {junk[CFG_DW-1:CNT_W], n};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		reg_writes++;
	endtask

	task automatic random_phase(input int words, input int lim);
		int add_w;
		int r;
		op_t op;
		add_w = $urandom_range(10, 50);
		repeat (words) begin
			r = $urandom_range(0, 99);
			if (r < add_w)
				op = OP_ADD;
			else if (r < 60)
				op = OP_REMOVE;
			else if (r < 95)
				op = OP_QUERY;
			else
				op = OP_NONE;
			send_word(op, pick_node(lim), pick_node(lim));
		end
	endtask

	// Result side: random stalls, a calm mode, and one long hold-off on request.
	initial begin
		int run;
		rsp_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				rsp_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				run = idle_len();
				if (run > 0) begin
					rsp_if.ready <= 1'b0;
					repeat (run) @(posedge clk);
				end
				rsp_if.ready <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		int settings [7];
		int lim;
		calm = 1'b0;
		hold_req = 1'b0;
		reg_writes = 0;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		cmd_if.valid <= 1'b0;
		cmd_if.opcode <= OP_ADD;
		cmd_if.from_node <= '0;
		cmd_if.to_node <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Corners at the reset node count: self query, duplicates, extremes.
		send_word(OP_QUERY, 4'd0, 4'd0);
		send_word(OP_QUERY, 4'd0, 4'd15);
		send_word(OP_ADD, 4'd0, 4'd1);
		send_word(OP_ADD, 4'd1, 4'd15);
		send_word(OP_ADD, 4'd15, 4'd0);
		send_word(OP_ADD, 4'd0, 4'd1);
		send_word(OP_QUERY, 4'd0, 4'd15);
		send_word(OP_QUERY, 4'd15, 4'd1);
		send_word(OP_REMOVE, 4'd1, 4'd15);
		send_word(OP_REMOVE, 4'd1, 4'd15);
		send_word(OP_QUERY, 4'd0, 4'd15);
		send_word(OP_NONE, 4'd15, 4'd15);
		send_word(OP_ADD, 4'd15, 4'd15);
		send_word(OP_REMOVE, 4'd15, 4'd15);
		send_word(OP_ADD, 4'd2, 4'd9);
		send_word(OP_ADD, 4'd9, 4'd3);
		send_word(OP_QUERY, 4'd2, 4'd3);
		// Shrunk node count: node 9 drops out, its edges stay counted.
		wait_idle();
		write_node_count(5'd4);
		send_word(OP_QUERY, 4'd2, 4'd3);
		send_word(OP_ADD, 4'd0, 4'd5);
		send_word(OP_REMOVE, 4'd15, 4'd0);
		send_word(OP_ADD, 4'd3, 4'd0);
		wait_idle();
		write_node_count(5'd0);
		send_word(OP_QUERY, 4'd0, 4'd0);
		wait_idle();
		write_node_count(5'd31);
		send_word(OP_QUERY, 4'd15, 4'd15);
		send_word(OP_QUERY, 4'd2, 4'd3);
		wait_idle();
		write_node_count(5'd1);
		send_word(OP_ADD, 4'd0, 4'd0);
		send_word(OP_QUERY, 4'd0, 4'd0);
		send_word(OP_QUERY, 4'd0, 4'd1);
		wait_idle();
		write_node_count(5'd16);

		// Fill the whole matrix back to back, then thin it out at random.
		calm = 1'b1;
		for (int u = 0; u < NODES_DEF; u++)
			for (int v = 0; v < NODES_DEF; v++)
				send_word(OP_ADD, NODE_W'(u), NODE_W'(v));
		calm = 1'b0;
		send_word(OP_QUERY, 4'd15, 4'd0);
		for (int u = 0; u < NODES_DEF; u++)
			for (int v = 0; v < NODES_DEF; v++)
				if ($urandom_range(0, 99) < 80)
					send_word(OP_REMOVE, NODE_W'(u), NODE_W'(v));

		// Long hold-off on the result side while words keep coming.
		hold_req = 1'b1;
		random_phase(30, NODES_DEF);

		settings = '{16, 7, 2, 31, 12, 0, 16};
		settings[5] = $urandom_range(1, 16);
		foreach (settings[i]) begin
			wait_idle();
			write_node_count(CNT_W'(settings[i]));
			lim = (settings[i] > NODES_DEF) ? NODES_DEF : settings[i];
			random_phase(48, lim);
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Summary: %0d result words checked over %0d node-count writes.",
			words_checked, reg_writes);
		$display("Traffic had %0d reachable queries and a peak of %0d stored edges.",
			paths_found, peak_edges);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
